### rtl/hsm_pkg.sv
// ----------------------------------------------------------------------------
// Heater safety monitor package
// Shared types, register indexes and reset values for the safety monitor.
// ----------------------------------------------------------------------------
package hsm_pkg;

    localparam int TEMP_W   = 13;
    localparam int PEAK_W   = 12;
    localparam int TIME_W   = 32;
    localparam int MARGIN_W = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SAFE_TEMP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_HEATING_MS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_MARGIN   = 2'd2;

    localparam logic [PEAK_W-1:0]   MAX_SAFE_TEMP_RST  = 12'd2640;
    localparam logic [TIME_W-1:0]   MAX_HEATING_MS_RST = 32'd300000;
    localparam logic [MARGIN_W-1:0] CLEAR_MARGIN_RST   = 10'd80;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature;
        logic                     heater_request;
        logic [TIME_W-1:0]        time_ms;
    } sample_t;

    typedef struct packed {
        logic [PEAK_W-1:0]   max_safe_temp;
        logic [TIME_W-1:0]   max_heating_ms;
        logic [MARGIN_W-1:0] clear_margin;
    } cfg_t;

    typedef struct packed {
        logic                heater_on;
        logic [TIME_W-1:0]   heat_start;
        logic [TIME_W-1:0]   heat_total;
        logic [PEAK_W-1:0]   peak_temp;
        logic                violation;
    } mon_state_t;

    typedef struct packed {
        logic                safe;
        logic                violation;
        logic [PEAK_W-1:0]   peak_temperature;
        logic [TIME_W-1:0]   heating_remaining_ms;
        logic [TIME_W-1:0]   total_heating_ms;
        logic                heater_tracked_on;
    } result_t;

endpackage

### rtl/hsm_eval.sv
// ----------------------------------------------------------------------------
// Heater safety monitor sample evaluation
// Computes the next monitor state and the result beat for one sample.
// ----------------------------------------------------------------------------
module hsm_eval (
    input  hsm_pkg::sample_t    sample,
    input  hsm_pkg::mon_state_t state,
    input  hsm_pkg::cfg_t       cfg,
    output hsm_pkg::mon_state_t state_next,
    output hsm_pkg::result_t    result
);

    logic                        heater_on;
    logic [hsm_pkg::TIME_W-1:0]  heat_start;
    logic [hsm_pkg::TIME_W-1:0]  elapsed;
    logic [hsm_pkg::TIME_W-1:0]  run_time;
    logic                        over_temp;
    logic                        too_long;
    logic                        below_clear;
    logic                        violation;
    logic signed [hsm_pkg::TEMP_W:0] clear_level;
    logic signed [hsm_pkg::TEMP_W:0] temp_ext;

    assign run_time   = sample.time_ms - state.heat_start;
    assign heater_on  = sample.heater_request;
    assign heat_start = (sample.heater_request && !state.heater_on) ? sample.time_ms
                                                                    : state.heat_start;
    assign elapsed    = sample.time_ms - heat_start;

    assign over_temp = sample.temperature > $signed({1'b0, cfg.max_safe_temp});
    assign too_long  = heater_on && (elapsed > cfg.max_heating_ms);

    assign temp_ext    = {sample.temperature[hsm_pkg::TEMP_W-1], sample.temperature};
    assign clear_level = $signed({2'b00, cfg.max_safe_temp})
                       - $signed({4'b0000, cfg.clear_margin});
    assign below_clear = temp_ext < clear_level;

    always_comb begin
        priority if (over_temp || too_long) begin
            violation = 1'b1;
        end else if (state.violation && !heater_on && below_clear) begin
            violation = 1'b0;
        end else begin
            violation = state.violation;
        end
    end

    always_comb begin
        state_next.heater_on  = heater_on;
        state_next.heat_start = heat_start;
        state_next.heat_total = (!sample.heater_request && state.heater_on)
                              ? state.heat_total + run_time : state.heat_total;
        state_next.peak_temp  = (sample.temperature > $signed({1'b0, state.peak_temp}))
                              ? sample.temperature[hsm_pkg::PEAK_W-1:0] : state.peak_temp;
        state_next.violation  = violation;
    end

    always_comb begin
        result.safe              = !(over_temp || too_long);
        result.violation         = violation;
        result.peak_temperature  = state_next.peak_temp;
        result.total_heating_ms  = state_next.heat_total;
        result.heater_tracked_on = heater_on;
        if (!heater_on) begin
            result.heating_remaining_ms = cfg.max_heating_ms;
        end else if (elapsed >= cfg.max_heating_ms) begin
            result.heating_remaining_ms = '0;
        end else begin
            result.heating_remaining_ms = cfg.max_heating_ms - elapsed;
        end
    end

endmodule

### rtl/heater_safety_monitor.sv
// ----------------------------------------------------------------------------
// Heater safety monitor
// Thermal runaway protection: over-temperature and heating-time limits with
// a latched violation, peak tracking and heating-time accounting.
// ----------------------------------------------------------------------------
// A sample beat is held in the input register until the result register is empty or taken.
// Throughput: one sample per cycle while results are taken, set by the single evaluation stage between
// the input register and the result register; state updates in that stage.
// Reset: synchronous, active low; clears valid flags and monitor state and
// loads the register reset values. No clearing pass is needed.
module heater_safety_monitor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic signed [12:0] s_temperature,
    input  logic        s_heater_request,
    input  logic [31:0] s_time_ms,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_safe,
    output logic        m_violation,
    output logic [11:0] m_peak_temperature,
    output logic [31:0] m_heating_remaining_ms,
    output logic [31:0] m_total_heating_ms,
    output logic        m_heater_tracked_on
);

    hsm_pkg::cfg_t       cfg_reg;
    hsm_pkg::mon_state_t state_reg;
    hsm_pkg::mon_state_t state_next;
    hsm_pkg::sample_t    in_sample_reg;
    hsm_pkg::result_t    out_result_reg;
    hsm_pkg::result_t    result_next;
    logic                in_vld_reg;
    logic                out_vld_reg;
    logic                advance;

    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;

    hsm_eval u_eval (
        .sample     (in_sample_reg),
        .state      (state_reg),
        .cfg        (cfg_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_safe_temp  <= hsm_pkg::MAX_SAFE_TEMP_RST;
            cfg_reg.max_heating_ms <= hsm_pkg::MAX_HEATING_MS_RST;
            cfg_reg.clear_margin   <= hsm_pkg::CLEAR_MARGIN_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                hsm_pkg::CFG_MAX_SAFE_TEMP: begin
                    cfg_reg.max_safe_temp <= cfg_wdata[hsm_pkg::PEAK_W-1:0];
                end
                hsm_pkg::CFG_MAX_HEATING_MS: begin
                    cfg_reg.max_heating_ms <= cfg_wdata[hsm_pkg::TIME_W-1:0];
                end
                hsm_pkg::CFG_CLEAR_MARGIN: begin
                    cfg_reg.clear_margin <= cfg_wdata[hsm_pkg::MARGIN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_sample_reg.temperature    <= s_temperature;
            in_sample_reg.heater_request <= s_heater_request;
            in_sample_reg.time_ms        <= s_time_ms;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            if (advance) begin
                state_reg <= state_next;
            end
            if (advance) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= result_next;
        end
    end

    assign m_valid                = out_vld_reg;
    assign m_safe                 = out_result_reg.safe;
    assign m_violation            = out_result_reg.violation;
    assign m_peak_temperature     = out_result_reg.peak_temperature;
    assign m_heating_remaining_ms = out_result_reg.heating_remaining_ms;
    assign m_total_heating_ms     = out_result_reg.total_heating_ms;
    assign m_heater_tracked_on    = out_result_reg.heater_tracked_on;

    // An unsafe beat always carries the latched violation.
    a_unsafe_latches: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_safe || m_violation))
        else $error("unsafe beat without violation");

    // The remaining time never exceeds the limit and equals it while the heater is off.
    a_remaining_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_heating_remaining_ms <= cfg_reg.max_heating_ms)
            && (m_heater_tracked_on || m_heating_remaining_ms == cfg_reg.max_heating_ms))
        else $error("remaining heating time out of range");

    // The peak temperature never decreases.
    a_peak_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> state_reg.peak_temp >= $past(state_reg.peak_temp))
        else $error("peak temperature decreased");

    // Monitor state moves only when a sample is evaluated.
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(state_reg))
        else $error("monitor state changed without a sample");

endmodule
